[sv/capacitive_charge_time_sensor_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the capacitive charge-time sensor
// Clocked on clk and held off during reset (rst_n low).
// ---------------------------------------------------------------------------
`ifndef CAPACITIVE_CHARGE_TIME_SENSOR_TOP_MACROS_SVH
`define CAPACITIVE_CHARGE_TIME_SENSOR_TOP_MACROS_SVH

// Property checked at every edge outside reset
`define CCTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Trigger this cycle, consequence in the next cycle
`define CCTS_ASSERT_NEXT(lbl, trig, cons, msg) \
    `CCTS_ASSERT(lbl, (trig) |=> (cons), msg)

`endif

[sv/ccts_pkg.sv]
// ---------------------------------------------------------------------------
// ccts_pkg
// Types and constants shared by the capacitive charge-time sensor.
// ---------------------------------------------------------------------------
package ccts_pkg;

    localparam int LIMIT_W     = 24;
    localparam int DISCH_W     = 16;
    localparam int SAMPLE_W    = 8;
    localparam int TOTAL_OUT_W = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_TICKS = 2'd1;

    localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST   = 24'd2480000;
    localparam logic [DISCH_W-1:0] DISCHARGE_TICKS_RST = 16'd640;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_DISCHARGE = 3'd1,
        PH_CHARGE    = 3'd2,
        PH_PRECHARGE = 3'd3,
        PH_FALL      = 3'd4
    } phase_t;

    typedef struct packed {
        logic                action;
        logic [SAMPLE_W-1:0] sample_count;
        logic                pin_level;
    } in_item_t;

    typedef struct packed {
        logic                   send_level;
        logic                   recv_drive_enable;
        logic                   recv_drive_level;
        logic                   done_res;
        logic                   status;
        logic [TOTAL_OUT_W-1:0] total;
    } out_item_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] timeout_limit;
        logic [DISCH_W-1:0] discharge_ticks;
    } cfg_t;

endpackage

[sv/ccts_chan_if.sv]
// ---------------------------------------------------------------------------
// ccts_chan_if
// Valid/ready channel with a typed payload.
// ---------------------------------------------------------------------------
interface ccts_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[sv/capacitive_charge_time_sensor_top.sv]
// ---------------------------------------------------------------------------
// capacitive_charge_time_sensor_top
// Charge/discharge timing of a capacitive pin with accumulated tick count.
// ---------------------------------------------------------------------------
// One item (a start or a clock tick with the sampled receive level) is
// accepted every cycle while neither side stalls, and each item gives
// exactly one result: the pin setting for the next phase, a done flag,
// timeout status and the running total. An item lands in the input register
// at its transfer edge, its result is loaded into the result register once
// that register is free, and the result then transfers from there. The
// combinational next-state logic of the phase machine sets the rate of one
// item per cycle. Either side may stall; the result register keeps a
// finished result while the next item is taken in.
// Registers: index 0 timeout_limit (reset 2480000), index 1 discharge_ticks
// (reset 640); write them only while no measurement item is in flight.
// TOTAL_BITS sets the width of the internal tick counter.
module capacitive_charge_time_sensor_top
    import ccts_pkg::*;
#(
    parameter int TOTAL_BITS = 24
) (
    input logic         clk,
    input logic         rst_n,
    ccts_chan_if.sink   sample_in,
    ccts_chan_if.source result_out,
    ccts_chan_if.sink   cfg_wr
);

    cfg_t      cfg_reg;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t core_result;
    logic      advance;
    logic      step;
    cfg_wr_t   wr;

    assign wr           = cfg_wr.payload;
    assign cfg_wr.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_limit   <= TIMEOUT_LIMIT_RST;
            cfg_reg.discharge_ticks <= DISCHARGE_TICKS_RST;
        end
        else if (cfg_wr.valid)
        begin
            unique case (wr.index)
                REG_TIMEOUT_LIMIT:   cfg_reg.timeout_limit   <= wr.data[LIMIT_W-1:0];
                REG_DISCHARGE_TICKS: cfg_reg.discharge_ticks <= wr.data[DISCH_W-1:0];
                default:             ;
            endcase
        end
    end

    // result register frees up when empty or when its transfer completes
    assign advance         = !out_valid_reg || result_out.ready;
    assign step            = s1_valid_reg && advance;
    assign sample_in.ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample_in.ready)
            begin
                s1_valid_reg <= sample_in.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_in.valid && sample_in.ready)
        begin
            s1_item_reg <= sample_in.payload;
        end
        if (step)
        begin
            out_item_reg <= core_result;
        end
    end

    ccts_core #(
        .TOTAL_BITS(TOTAL_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (s1_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    assign result_out.valid   = out_valid_reg;
    assign result_out.payload = out_item_reg;

endmodule

[sv/ccts_core.sv]
// ---------------------------------------------------------------------------
// ccts_core
// Measurement state machine: phase, running count, samples and discharge
// timer. Computes one result per step and updates state on the step.
// ---------------------------------------------------------------------------
module ccts_core
    import ccts_pkg::*;
#(
    parameter int TOTAL_BITS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam int CMP_W = (TOTAL_BITS > LIMIT_W) ? TOTAL_BITS : LIMIT_W;

    phase_t              phase_reg, phase_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic [SAMPLE_W-1:0] samples_reg, samples_next;
    logic [DISCH_W-1:0]  wait_reg, wait_next;

    logic [TOTAL_BITS-1:0] total_inc;
    logic [CMP_W-1:0]      limit_ext;
    logic                  at_limit;
    logic                  at_max;
    logic                  inc_hit;
    logic                  done;
    logic                  stat;

    assign total_inc = total_reg + TOTAL_BITS'(1);
    assign limit_ext = CMP_W'(cfg.timeout_limit);
    assign at_limit  = CMP_W'(total_reg) >= limit_ext;
    assign at_max    = &total_reg;
    assign inc_hit   = (CMP_W'(total_inc) >= limit_ext) || (&total_inc);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            total_reg   <= '0;
            samples_reg <= '0;
            wait_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            total_reg   <= total_next;
            samples_reg <= samples_next;
            wait_reg    <= wait_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        total_next   = total_reg;
        samples_next = samples_reg;
        wait_next    = wait_reg;
        done         = 1'b0;
        stat         = 1'b0;

        if (item.action)
        begin
            total_next = '0;
            if (item.sample_count == '0)
            begin
                done = 1'b1;
            end
            else
            begin
                samples_next = item.sample_count;
                phase_next   = PH_DISCHARGE;
                wait_next    = cfg.discharge_ticks;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_DISCHARGE:
                begin
                    if (wait_reg <= DISCH_W'(1))
                    begin
                        wait_next  = '0;
                        phase_next = PH_CHARGE;
                    end
                    else
                    begin
                        wait_next = wait_reg - DISCH_W'(1);
                    end
                end
                PH_CHARGE, PH_FALL:
                begin
                    if (at_limit)
                    begin
                        done = 1'b1;
                        stat = 1'b1;
                    end
                    else if (item.pin_level == (phase_reg == PH_FALL))
                    begin
                        // still counting: saturated counter also aborts
                        if (at_max)
                        begin
                            done = 1'b1;
                            stat = 1'b1;
                        end
                        else
                        begin
                            total_next = total_inc;
                            if (inc_hit)
                            begin
                                done = 1'b1;
                                stat = 1'b1;
                            end
                        end
                    end
                    else if (phase_reg == PH_CHARGE)
                    begin
                        phase_next = PH_PRECHARGE;
                    end
                    else
                    begin
                        samples_next = samples_reg - SAMPLE_W'(1);
                        if (samples_reg == SAMPLE_W'(1))
                        begin
                            done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DISCHARGE;
                            wait_next  = cfg.discharge_ticks;
                        end
                    end
                end
                PH_PRECHARGE:
                begin
                    phase_next = PH_FALL;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (done)
        begin
            phase_next   = PH_IDLE;
            samples_next = '0;
            wait_next    = '0;
        end

        result.send_level        = (phase_next == PH_CHARGE) || (phase_next == PH_PRECHARGE);
        result.recv_drive_enable = (phase_next == PH_DISCHARGE) || (phase_next == PH_PRECHARGE);
        result.recv_drive_level  = (phase_next == PH_PRECHARGE);
        result.done_res          = done;
        result.status            = stat;
        result.total             = TOTAL_OUT_W'(total_next);
    end

endmodule

[sv/ccts_checker.sv]
// ---------------------------------------------------------------------------
// ccts_checker
// Port-level checks on the result channel of the sensor.
// ---------------------------------------------------------------------------
`include "capacitive_charge_time_sensor_top_macros.svh"

module ccts_checker
    import ccts_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // a stalled result holds
    `CCTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result changed while stalled")

    // timeout status only on a finishing result
    `CCTS_ASSERT(a_status_done, !out_valid || !out_item.status || out_item.done_res, "status set without done")

    // receive pin level only meaningful when driven
    `CCTS_ASSERT(a_drive_level, !out_valid || !out_item.recv_drive_level || out_item.recv_drive_enable, "drive level without enable")

    // a finished measurement leaves the receive pin released and send low
    `CCTS_ASSERT(a_done_idle, !out_valid || !out_item.done_res || (!out_item.send_level && !out_item.recv_drive_enable), "pins active after done")

endmodule

bind capacitive_charge_time_sensor_top ccts_checker u_ccts_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_item  (result_out.payload)
);
